/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/slpq_pkg.sv */
// ---------------------------------------------------------------------------
// slpq_pkg
// Types and constants shared by the sorted list priority queue files
// ---------------------------------------------------------------------------
`default_nettype none

package slpq_pkg;

  // field widths
  localparam int DATA_W = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // default number of stored values
  localparam int DEPTH_DEFAULT = 16;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_DUMP   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_HEAD,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_DUMP,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* src/slpq_ram.sv */
// ---------------------------------------------------------------------------
// slpq_ram
// Generic single write, single read RAM with a registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module slpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/sorted_list_priority_queue.sv */
// ---------------------------------------------------------------------------
// sorted_list_priority_queue
// Bounded priority queue of signed 8-bit values kept in ascending order
// ---------------------------------------------------------------------------
// Usage:
//   Request beats (opcode, value) enter on in_valid/in_ready; result beats
//   (status, data, last) leave on out_valid/out_ready. in_ready is high only
//   while the sequencer is idle, so one request is worked on at a time.
//   The values sit in one RAM with a registered read; each step of the
//   sequencer does at most one RAM read and one RAM write, on that single port pair.
//   Insert into an empty queue writes the head, else larger or equal values
//     move up one slot, top first. Remove reads the head, then moves the rest
//     down one slot. Full and empty requests go straight to the result. Dump:
//     one beat per cycle when the receiver keeps out_ready high.
//   Each request gives one result beat, except dump with occupancy values
//   (one beat per value, last on the final one) and opcode three (none).
//   Results go through an output register; when the receiver stalls, the
//   beat holds and the sequencer waits before loading the next one.
//   Reset clears the occupancy and the output valid; the RAM is not cleared,
//   entries at or above the occupancy are never read.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_list_priority_queue
  import slpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_W-1:0]          opcode,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             status,
  output logic signed [DATA_W-1:0]      data,
  output logic                          last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0]     occ, occ_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     idx, idx_next;
  logic [DATA_W-1:0] val, val_next;
  status_t           resp_status, resp_status_next;
  logic [DATA_W-1:0] resp_data, resp_data_next;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  logic              load_out;
  status_t           out_status_next;
  logic [DATA_W-1:0] out_data_next;
  logic              out_last_next;

  logic in_fire, can_load;
  logic occ_zero, occ_full, idx_one, cnt_one, seq_end, ins_stop;

  // value store
  slpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // handshake and shared conditions
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign can_load = !out_valid || out_ready;
  assign occ_zero = (occ == '0);
  assign occ_full = (occ == CW'(DEPTH));
  assign idx_one  = (idx == AW'(1));
  assign cnt_one  = (cnt == CW'(1));
  assign seq_end  = ((CW'(idx) + CW'(1)) == cnt);
  assign ins_stop = ($signed(val) > $signed(ram_rd_data));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (opcode)
            OP_DUMP:   state_next = occ_zero ? S_RESP : S_DUMP;
            OP_INSERT: begin
              if (occ_full) begin
                state_next = S_RESP;
              end else begin
                state_next = occ_zero ? S_INS_HEAD : S_INS_CMP;
              end
            end
            OP_REMOVE: state_next = occ_zero ? S_RESP : S_REM_HEAD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_INS_CMP: begin
        if (ins_stop) begin
          state_next = S_RESP;
        end else if (idx_one) begin
          state_next = S_INS_HEAD;
        end
      end
      S_INS_HEAD:  state_next = S_RESP;
      S_REM_HEAD:  state_next = cnt_one ? S_RESP : S_REM_SHIFT;
      S_REM_SHIFT: state_next = seq_end ? S_RESP : S_REM_SHIFT;
      S_DUMP: begin
        if (can_load && seq_end) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    occ_next         = occ;
    cnt_next         = cnt;
    idx_next         = idx;
    val_next         = val;
    resp_status_next = resp_status;
    resp_data_next   = resp_data;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = idx;
    ram_wr_data      = ram_rd_data;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = idx;
    load_out         = 1'b0;
    out_status_next  = resp_status;
    out_data_next    = resp_data;
    out_last_next    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cnt_next       = occ;
          resp_data_next = '0;
          unique case (opcode)
            OP_DUMP: begin
              if (occ_zero) begin
                resp_status_next = STAT_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                idx_next    = '0;
              end
            end
            OP_INSERT: begin
              if (occ_full) begin
                resp_status_next = STAT_FULL;
              end else begin
                resp_status_next = STAT_INSERTED;
                val_next         = value;
                occ_next         = occ + CW'(1);
                idx_next         = occ[AW-1:0];
                if (!occ_zero) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = occ[AW-1:0] - AW'(1);
                end
              end
            end
            OP_REMOVE: begin
              if (occ_zero) begin
                resp_status_next = STAT_EMPTY;
              end else begin
                resp_status_next = STAT_OK;
                occ_next         = occ - CW'(1);
                ram_rd_en        = 1'b1;
                ram_rd_addr      = '0;
              end
            end
            default: begin
              cnt_next = cnt;
            end
          endcase
        end
      end
      // walk down from the top, moving larger or equal values up one slot
      S_INS_CMP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx;
        if (ins_stop) begin
          ram_wr_data = val;
        end else begin
          ram_wr_data = ram_rd_data;
          if (!idx_one) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx - AW'(1) - AW'(1);
            idx_next    = idx - AW'(1);
          end
        end
      end
      S_INS_HEAD: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = val;
      end
      // capture the head, then start moving the rest down
      S_REM_HEAD: begin
        resp_data_next = ram_rd_data;
        if (!cnt_one) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(1);
          idx_next    = AW'(1);
        end
      end
      S_REM_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx - AW'(1);
        ram_wr_data = ram_rd_data;
        if (!seq_end) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx + AW'(1);
          idx_next    = idx + AW'(1);
        end
      end
      // one value per beat, next read issued as the current one is loaded
      S_DUMP: begin
        if (can_load) begin
          load_out        = 1'b1;
          out_status_next = STAT_OK;
          out_data_next   = ram_rd_data;
          out_last_next   = seq_end;
          if (!seq_end) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx + AW'(1);
            idx_next    = idx + AW'(1);
          end
        end
      end
      S_RESP: begin
        if (can_load) begin
          load_out = 1'b1;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cnt         <= cnt_next;
    idx         <= idx_next;
    val         <= val_next;
    resp_status <= resp_status_next;
    resp_data   <= resp_data_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status <= out_status_next;
      data   <= $signed(out_data_next);
      last   <= out_last_next;
    end
  end

endmodule

`default_nettype wire

/* src/slpq_checker.sv */
// ---------------------------------------------------------------------------
// slpq_checker
// Port-level checks on the sorted list priority queue, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slpq_checker
  import slpq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [STAT_W-1:0]        status,
  input wire logic signed [DATA_W-1:0] data,
  input wire logic                     last
);

  logic                       out_fire;
  logic                       out_stall;
  logic                       no_value_status;
  logic [STAT_W+DATA_W:0]     out_beat;

  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_beat  = {status, data, last};
  assign no_value_status = (status == STAT_INSERTED) || (status == STAT_FULL) ||
                           (status == STAT_EMPTY);

  // a stalled result beat holds
  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_beat), "stalled beat changed")

  // nothing is offered right after reset
  `ASSERT_CLK_ALWAYS(a_reset_quiet, $past(rst) |-> !out_valid, "result valid right after reset")

  // status-only results always close their request
  `ASSERT_CLK(a_status_last, out_valid && (status != STAT_OK) |-> last, "status without last")

  // status-only results carry zero data
  `ASSERT_CLK(a_status_zero, out_valid && no_value_status |-> data == '0, "status with data")

  // no new request is taken while a non-final beat is being delivered
  `ASSERT_CLK(a_busy_dump, out_fire && !last |-> !in_ready, "request taken mid dump")

endmodule

bind sorted_list_priority_queue slpq_checker u_slpq_checker (.*);

`default_nettype wire

/* tb/sorted_list_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_priority_queue_tb
// Self-checking testbench for the bounded sorted priority queue
// ---------------------------------------------------------------------------
// Request beats go in on a valid/ready channel. A sorted-list model is
// updated at each accepted request and queues the result beats it
// predicts. A monitor compares every accepted result beat, field by field,
// against the oldest queued prediction. A directed sequence covers the
// empty, full, extreme-value, duplicate and unused-opcode cases. Random
// traffic then swings the queue between empty and full under three
// idle/stall mixes.
// ---------------------------------------------------------------------------

module sorted_list_priority_queue_tb;
  import slpq_pkg::*;

  localparam int QDEPTH = DEPTH_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * QDEPTH + 8;
  localparam int MAX_REPORTS = 10;

  // one predicted result beat
  typedef struct {
    status_t                   status_code;
    logic signed [DATA_W-1:0]  payload;
    logic                      is_last;
  } result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [OP_W-1:0]           opcode;
  logic signed [DATA_W-1:0]  value;
  logic                      out_valid;
  logic                      out_ready;
  logic [STAT_W-1:0]         status;
  logic signed [DATA_W-1:0]  data;
  logic                      last;

  // model state and predictions
  logic signed [DATA_W-1:0]  sorted_values[$];
  result_t                   expected_beats[$];
  result_t                   head_beat;

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int beats_checked;
  int insert_count, remove_count, dump_count, unused_count;
  int full_hits, empty_hits;

  sorted_list_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .last      (last)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // error reporting, only the first few are printed
  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  function automatic void queue_result(input status_t st, input logic signed [DATA_W-1:0] d,
                                       input logic l);
    result_t r;
    r.status_code = st;
    r.payload = d;
    r.is_last = l;
    expected_beats.push_back(r);
  endfunction

  // sorted-list model: apply one accepted request, queue its result beats
  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val);
    int pos;
    case (op)
      OP_DUMP: begin
        dump_count++;
        if (sorted_values.size() == 0) begin
          empty_hits++;
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          foreach (sorted_values[i]) begin
            queue_result(STAT_OK, sorted_values[i], i == sorted_values.size() - 1);
          end
        end
      end
      OP_INSERT: begin
        insert_count++;
        if (sorted_values.size() >= QDEPTH) begin
          full_hits++;
          queue_result(STAT_FULL, '0, 1'b1);
        end else begin
          // new value goes ahead of the first entry that is not smaller
          pos = 0;
          while (pos < sorted_values.size() && val > sorted_values[pos]) pos++;
          sorted_values.insert(pos, val);
          queue_result(STAT_INSERTED, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        remove_count++;
        if (sorted_values.size() == 0) begin
          empty_hits++;
          queue_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          queue_result(STAT_OK, sorted_values.pop_front(), 1'b1);
        end
      end
      default: begin
        unused_count++;
      end
    endcase
  endfunction

  // drive one request beat, return on the edge that accepts it
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    value <= val;
    // ready is stable mid-cycle, so the next rising edge takes the beat
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_request(op, val);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // result monitor: a beat seen mid-cycle with valid and ready is taken next edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_error($sformatf("unexpected beat status=%0d data=%0d last=%0b",
                               status, data, last));
      end else begin
        head_beat = expected_beats.pop_front();
        if (status !== head_beat.status_code) begin
          report_error($sformatf("status expected %0d got %0d",
                                 head_beat.status_code, status));
        end
        if (data !== head_beat.payload) begin
          report_error($sformatf("data expected %0d got %0d", head_beat.payload, data));
        end
        if (last !== head_beat.is_last) begin
          report_error($sformatf("last expected %0b got %0b", head_beat.is_last, last));
        end
      end
    end
  end

  // empty, full, extremes, duplicates and the unused opcode
  task automatic test_corner_cases();
    src_idle_pct = 11;
    sink_stall_pct = 50;
    send_request(OP_DUMP, 8'sd5);
    send_request(OP_REMOVE, -8'sd7);
    send_request(OP_UNUSED, 8'($urandom));
    send_request(OP_INSERT, 8'sd127);
    send_request(OP_INSERT, -8'sd128);
    send_request(OP_INSERT, 8'sd0);
    send_request(OP_INSERT, -8'sd1);
    send_request(OP_INSERT, 8'sd0);
    send_request(OP_DUMP, 8'sd0);
    send_request(OP_REMOVE, 8'sd0);
    // fill up to capacity, extremes again among the values
    send_request(OP_INSERT, -8'sd128);
    send_request(OP_INSERT, 8'sd127);
    for (int k = 0; k < QDEPTH - 6; k++) begin
      send_request(OP_INSERT, 8'($urandom));
    end
    send_request(OP_INSERT, 8'sd42);
    send_request(OP_DUMP, 8'sd0);
    send_request(OP_REMOVE, 8'sd0);
  endtask

  // random traffic that swings between filling and draining
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int sent;
    int pick;
    bit filling;
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] val;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    filling = (sorted_values.size() < QDEPTH / 2);
    while (sent < count) begin
      // linger a little at full and empty before turning around
      if (sorted_values.size() >= QDEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (sorted_values.size() == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < 13) op = OP_DUMP;
      else if (pick < (filling ? 75 : 38)) op = OP_INSERT;
      else op = OP_REMOVE;
      // extremes, a narrow band for duplicates, otherwise anything
      case ($urandom_range(0, 9))
        0: val = -8'sd128;
        1: val = 8'sd127;
        2, 3, 4: val = $signed(8'($urandom_range(0, 6))) - 8'sd3;
        default: val = 8'($urandom);
      endcase
      send_request(op, val);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  // stop driving, wait for outstanding beats, then let the block settle
  task automatic finish_run();
    int drain_cycles;
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_beats.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) begin
      report_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_DUMP;
    value = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    beats_checked = 0;
    insert_count = 0;
    remove_count = 0;
    dump_count = 0;
    unused_count = 0;
    full_hits = 0;
    empty_hits = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_random_traffic(148, 11, 50);
    test_random_traffic(148, 50, 11);
    test_random_traffic(149, 0, 0);
    finish_run();

    $display("run: %0d inserts, %0d removes, %0d dumps, %0d unused requests, %0d beats checked",
             insert_count, remove_count, dump_count, unused_count, beats_checked);
    $display("run: %0d inserts hit a full queue, %0d removes or dumps hit an empty one",
             full_hits, empty_hits);
    if (mismatch_count == 0) begin
      $display("sorted_list_priority_queue verification clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("sorted_list_priority_queue verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for the queue");
    $display("sorted_list_priority_queue verification failed");
    $finish;
  end

endmodule
